FILE: sv/path_canonicalizer_macros.svh
// Assertion macros shared by the path canonicalizer RTL.
`ifndef PATH_CANONICALIZER_MACROS_SVH
`define PATH_CANONICALIZER_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define PC_CHECK(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// A condition that must hold in the same cycle whenever a trigger is seen.
`define PC_CHECK_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

FILE: sv/pcanon_pkg.sv
// Package with the constants, codes and types of the path canonicalizer.
`default_nettype none

package pcanon_pkg;

   localparam int PATH_MAX    = 256;
   localparam int PTR_W       = $clog2(PATH_MAX);
   localparam int POS_W       = PTR_W + 1;
   localparam int STACK_DEPTH = PATH_MAX / 2;
   localparam int STACK_LIMIT = PATH_MAX / 2 - 1;
   localparam int SP_W        = $clog2(STACK_DEPTH);

   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_DOT   = 8'h2E;

   typedef enum logic [1:0] {
      OP_BYTE = 2'd0,
      OP_END  = 2'd1,
      OP_READ = 2'd2,
      OP_NONE = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_ACCEPT = 2'd0,
      ST_OK     = 2'd1,
      ST_FAIL   = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      K_EMPTY  = 2'd0,
      K_DOT    = 2'd1,
      K_DOTDOT = 2'd2,
      K_NAME   = 2'd3
   } kind_type;

endpackage

`default_nettype wire

FILE: sv/path_canonicalizer.sv
// Top level of the path canonicalizer: streams path bytes into a canonical absolute path.
`default_nettype none

//  Channel   Direction  Ports                                        Handshake
//  req       in         req_opcode, req_path_byte, req_read_index    req_valid / req_stall
//  rsp       out        rsp_status, rsp_out_length, rsp_out_byte     rsp_valid / rsp_stall
//
// The block takes one word per cycle on req unless req is stalled, and returns one
// word per request on rsp. A result passes through a first stage, which holds the
// synchronous read of the byte store, and then through the output register.
// The synchronous read of the component-stack memory is covered by a cached top entry,
// which a pop refills from the memory in the following cycle.
// Reset is synchronous and active high; no clearing pass runs, since the memories are
// only read at entries written earlier in the same path.
// A stalled rsp holds its word; req is stalled only when both result stages are full.

module path_canonicalizer
   import pcanon_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,

   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [1:0] req_opcode,
   input  wire logic [7:0] req_path_byte,
   input  wire logic [7:0] req_read_index,

   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [1:0]      rsp_status,
   output logic [7:0]      rsp_out_length,
   output logic [7:0]      rsp_out_byte
);

   // Path state registers.
   logic [POS_W-1:0] wp_ff, wp_in;
   logic [POS_W-1:0] seg_ff, seg_in;
   logic [SP_W-1:0]  sc_ff, sc_in;
   kind_type         kind_ff, kind_in;
   logic [POS_W-1:0] cnt_ff, cnt_in;
   logic             err_ff, err_in;
   logic             closed_ff, closed_in;

   // Cached top of the component stack and its refill flag.
   logic [PTR_W-1:0] top_ff, top_in;
   logic             refill_ff, refill_in;
   logic [PTR_W-1:0] top_cur;

   // Byte store: written at one address, read at one address per cycle.
   logic [7:0]       store_mem [PATH_MAX];
   logic [7:0]       st_rd_ff;
   logic             st_we;
   logic [PTR_W-1:0] st_addr;
   logic [7:0]       st_wdata;

   // Component stack memory, holding the start position of each kept component.
   logic [PTR_W-1:0] stk_mem [STACK_DEPTH];
   logic [PTR_W-1:0] stk_rd_ff;
   logic             stk_we;
   logic [SP_W-1:0]  stk_raddr;
   logic             pop_en;

   // Effective state, after an implied start of a new path.
   logic             start_path;
   logic [POS_W-1:0] e_wp, e_seg, e_cnt;
   logic [SP_W-1:0]  e_sc;
   kind_type         e_kind;
   logic             e_err;

   // Result of closing the current segment from the effective state.
   logic [POS_W-1:0] cl_wp;
   logic [SP_W-1:0]  cl_sc;
   logic             cl_err;
   logic             cl_push;
   logic             cl_pop;
   logic             end_err;

   logic [POS_W-1:0] byte_pos;

   // Handshake and pipeline stages.
   opcode_type       op;
   logic             accept;
   logic             s1_valid_ff, s1_valid_in;
   logic             s1_move;
   status_type       s1_status_ff, res_status;
   logic [7:0]       s1_length_ff, res_length;
   logic             s1_hit_ff, res_hit;
   logic             s1_root_ff, res_root;
   logic [7:0]       s1_byte;

   logic             rsp_valid_ff, rsp_valid_in;
   status_type       rsp_status_ff;
   logic [7:0]       rsp_out_length_ff;
   logic [7:0]       rsp_out_byte_ff;

   assign op        = opcode_type'(req_opcode);
   assign s1_move   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !s1_move;
   assign accept    = req_valid && !req_stall;

   assign top_cur = refill_ff ? stk_rd_ff : top_ff;

   // A path byte or an end that arrives after a closed path first opens a new path,
   // whose store holds only the root slash.
   assign start_path = closed_ff &&
                       ((op == OP_BYTE && req_path_byte != 8'd0) || op == OP_END);

   always_comb begin
      if (start_path) begin
         e_wp   = POS_W'(1);
         e_seg  = POS_W'(1);
         e_sc   = '0;
         e_kind = K_EMPTY;
         e_cnt  = '0;
         e_err  = 1'b0;
      end else begin
         e_wp   = wp_ff;
         e_seg  = seg_ff;
         e_sc   = sc_ff;
         e_kind = kind_ff;
         e_cnt  = cnt_ff;
         e_err  = err_ff;
      end
   end

   // Closing a segment drops empty and dot segments, pops one kept component for a
   // double dot and pushes the start of a named component, or fails if the stack is full.
   always_comb begin
      cl_wp   = e_wp;
      cl_sc   = e_sc;
      cl_err  = e_err;
      cl_push = 1'b0;
      cl_pop  = 1'b0;
      unique case (e_kind)
         K_EMPTY, K_DOT: begin
            cl_wp = e_seg;
         end
         K_DOTDOT: begin
            cl_wp = e_seg;
            if (e_sc != '0) begin
               cl_sc  = e_sc - 1'b1;
               cl_wp  = {1'b0, top_cur};
               cl_pop = 1'b1;
            end
         end
         K_NAME: begin
            if (32'(e_sc) >= STACK_LIMIT) begin
               cl_err = 1'b1;
            end else begin
               cl_push = 1'b1;
               cl_sc   = e_sc + 1'b1;
            end
         end
         default: begin
            cl_wp = e_seg;
         end
      endcase
   end

   // The separator in front of a component is written when the slash that ends the
   // previous segment arrives, so every path byte writes the store at most once.
   always_comb begin
      wp_in      = wp_ff;
      seg_in     = seg_ff;
      sc_in      = sc_ff;
      kind_in    = kind_ff;
      cnt_in     = cnt_ff;
      err_in     = err_ff;
      closed_in  = closed_ff;
      st_we      = 1'b0;
      st_addr    = '0;
      st_wdata   = '0;
      stk_we     = 1'b0;
      pop_en     = 1'b0;
      byte_pos   = e_wp;
      end_err    = e_err;
      res_status = ST_ACCEPT;
      res_length = '0;
      res_hit    = 1'b0;
      res_root   = 1'b0;

      if (accept) begin
         unique case (op)
            OP_BYTE: begin
               if (req_path_byte != 8'd0) begin
                  wp_in     = e_wp;
                  seg_in    = e_seg;
                  sc_in     = e_sc;
                  kind_in   = e_kind;
                  cnt_in    = e_cnt;
                  err_in    = e_err;
                  closed_in = 1'b0;
                  if (!e_err) begin
                     cnt_in = e_cnt + 1'b1;
                     if (32'(cnt_in) >= PATH_MAX) begin
                        err_in = 1'b1;
                     end else if (req_path_byte == CH_SLASH) begin
                        wp_in   = cl_wp;
                        sc_in   = cl_sc;
                        err_in  = cl_err;
                        kind_in = K_EMPTY;
                        seg_in  = cl_wp;
                        stk_we  = cl_push;
                        pop_en  = cl_pop;
                        if (cl_sc != '0 && 32'(cl_wp) < PATH_MAX) begin
                           st_we    = 1'b1;
                           st_addr  = PTR_W'(cl_wp);
                           st_wdata = CH_SLASH;
                        end
                     end else begin
                        if (e_kind == K_EMPTY) begin
                           seg_in = e_wp;
                           if (e_sc != '0) begin
                              byte_pos = e_wp + 1'b1;
                           end
                        end
                        if (32'(byte_pos) < PATH_MAX) begin
                           st_we    = 1'b1;
                           st_addr  = PTR_W'(byte_pos);
                           st_wdata = req_path_byte;
                        end
                        wp_in = byte_pos + 1'b1;
                        if (req_path_byte == CH_DOT && e_kind == K_EMPTY) begin
                           kind_in = K_DOT;
                        end else if (req_path_byte == CH_DOT && e_kind == K_DOT) begin
                           kind_in = K_DOTDOT;
                        end else begin
                           kind_in = K_NAME;
                        end
                     end
                  end
               end
            end
            OP_END: begin
               wp_in   = e_wp;
               seg_in  = e_seg;
               sc_in   = e_sc;
               kind_in = e_kind;
               cnt_in  = e_cnt;
               if (!e_err) begin
                  wp_in   = cl_wp;
                  sc_in   = cl_sc;
                  kind_in = K_EMPTY;
                  stk_we  = cl_push;
                  pop_en  = cl_pop;
                  end_err = cl_err;
                  if (32'(cl_wp) > PATH_MAX - 1) begin
                     end_err = 1'b1;
                  end
               end
               err_in    = end_err;
               closed_in = 1'b1;
               if (end_err) begin
                  res_status = ST_FAIL;
               end else begin
                  res_status = ST_OK;
                  res_length = 8'(cl_wp);
               end
            end
            OP_READ: begin
               res_hit  = closed_ff && !err_ff &&
                          (32'(req_read_index) < 32'(wp_ff)) &&
                          (32'(req_read_index) < PATH_MAX);
               res_root = (req_read_index == 8'd0);
            end
            OP_NONE: begin
               res_status = ST_ACCEPT;
            end
            default: begin
               res_status = ST_ACCEPT;
            end
         endcase
      end
   end

   // After a pop the new top sits one entry further down; it is read now and used
   // from the next cycle on. A push replaces the cached top directly.
   assign stk_raddr = cl_sc - 1'b1;
   assign refill_in = pop_en && (cl_sc != '0);
   assign top_in    = stk_we ? PTR_W'(e_seg) : top_cur;

   always_comb begin
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_comb begin
      if (s1_move) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Position zero always holds the root slash and is never stored.
   assign s1_byte = s1_hit_ff ? (s1_root_ff ? CH_SLASH : st_rd_ff) : 8'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff        <= '0;
         seg_ff       <= '0;
         sc_ff        <= '0;
         kind_ff      <= K_EMPTY;
         cnt_ff       <= '0;
         err_ff       <= 1'b0;
         closed_ff    <= 1'b1;
         refill_ff    <= 1'b0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wp_ff        <= wp_in;
         seg_ff       <= seg_in;
         sc_ff        <= sc_in;
         kind_ff      <= kind_in;
         cnt_ff       <= cnt_in;
         err_ff       <= err_in;
         closed_ff    <= closed_in;
         refill_ff    <= refill_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff <= top_in;
      if (accept) begin
         s1_status_ff <= res_status;
         s1_length_ff <= res_length;
         s1_hit_ff    <= res_hit;
         s1_root_ff   <= res_root;
      end
      if (s1_move) begin
         rsp_status_ff     <= s1_status_ff;
         rsp_out_length_ff <= s1_length_ff;
         rsp_out_byte_ff   <= s1_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (st_we) begin
         store_mem[st_addr] <= st_wdata;
      end
      if (accept && op == OP_READ) begin
         st_rd_ff <= store_mem[PTR_W'(req_read_index)];
      end
   end

   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk_mem[e_sc] <= PTR_W'(e_seg);
      end
      stk_rd_ff <= stk_mem[stk_raddr];
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_out_length = rsp_out_length_ff;
   assign rsp_out_byte   = rsp_out_byte_ff;

`include "path_canonicalizer_macros.svh"

   `PC_CHECK(a_stack_bound, 32'(sc_ff) <= STACK_LIMIT, "component stack count out of range")
   `PC_CHECK_IMP(a_pop_spacing, refill_ff, !pop_en, "pop while the stack top is refilling")
   `PC_CHECK_IMP(a_full_stall, s1_valid_ff && rsp_valid_ff && rsp_stall, req_stall,
                 "request taken while both result stages are full")
   `PC_CHECK_IMP(a_ok_length, rsp_valid_ff && rsp_status_ff == ST_OK,
                 rsp_out_length_ff != 8'd0, "finished path reported with zero length")

endmodule

`default_nettype wire

FILE: sim/path_canonicalizer_tb.sv
// Self-checking testbench for the path canonicalizer: streamed paths, reads, error paths.
`timescale 1ns / 100ps

import pcanon_pkg::*;

typedef struct packed {
   status_type status;
   logic [7:0] length;
   logic [7:0] data;
} canon_word_type;

// Tracks the canonical path that the block should be building and queues the
// result word that each accepted request word must produce.
class path_scoreboard;
   logic [7:0]     store [PATH_MAX];
   int unsigned    starts [STACK_DEPTH];
   int unsigned    depth;
   int unsigned    wpos;
   int unsigned    seg_start;
   int unsigned    in_count;
   kind_type       kind;
   bit             failed;
   bit             closed;
   canon_word_type waiting [$];
   int             errors;

   function new();
      depth = 0;
      wpos = 0;
      seg_start = 0;
      in_count = 0;
      kind = K_EMPTY;
      failed = 0;
      closed = 1;
      errors = 0;
   endfunction

   function void open_path();
      store[0] = CH_SLASH;
      wpos = 1;
      seg_start = 1;
      depth = 0;
      kind = K_EMPTY;
      in_count = 0;
      failed = 0;
      closed = 0;
   endfunction

   function void append_byte(logic [7:0] b);
      if (wpos < PATH_MAX) store[wpos] = b;
      wpos++;
   endfunction

   function void end_component();
      case (kind)
         K_EMPTY, K_DOT: begin
            wpos = seg_start;
         end
         K_DOTDOT: begin
            wpos = seg_start;
            if (depth > 0) begin
               depth--;
               wpos = starts[depth];
            end
         end
         default: begin
            if (depth >= STACK_LIMIT) failed = 1;
            else begin
               starts[depth] = seg_start;
               depth++;
            end
         end
      endcase
      kind = K_EMPTY;
   endfunction

   function void consume_byte(logic [7:0] b);
      in_count++;
      if (in_count >= PATH_MAX) begin
         failed = 1;
         return;
      end
      if (b == CH_SLASH) begin
         end_component();
         seg_start = wpos;
         return;
      end
      if (kind == K_EMPTY) begin
         seg_start = wpos;
         if (depth > 0) append_byte(CH_SLASH);
      end
      append_byte(b);
      if (b == CH_DOT && kind == K_EMPTY) kind = K_DOT;
      else if (b == CH_DOT && kind == K_DOT) kind = K_DOTDOT;
      else kind = K_NAME;
   endfunction

   function void note_request(opcode_type op, logic [7:0] b, logic [7:0] idx);
      canon_word_type w;
      w = '{ST_ACCEPT, 8'd0, 8'd0};
      case (op)
         OP_BYTE: begin
            if (b != 8'd0) begin
               if (closed) open_path();
               if (!failed) consume_byte(b);
            end
         end
         OP_END: begin
            if (closed) open_path();
            if (!failed) end_component();
            if (!failed && wpos > PATH_MAX - 1) failed = 1;
            closed = 1;
            if (failed) w.status = ST_FAIL;
            else begin
               w.status = ST_OK;
               w.length = 8'(wpos);
            end
         end
         OP_READ: begin
            if (closed && !failed && idx < wpos) w.data = store[idx];
         end
         default: ;
      endcase
      waiting.push_back(w);
   endfunction

   task report(string what, int got, int want);
      $display("%0t mismatch: %s got %0d want %0d", $realtime, what, got, want);
      errors++;
   endtask

   task check_result(logic [1:0] st, logic [7:0] len, logic [7:0] data);
      canon_word_type w;
      if (waiting.size() == 0) begin
         report("unexpected word, status", st, 0);
         return;
      end
      w = waiting.pop_front();
      if (st !== w.status) report("status", st, w.status);
      if (len !== w.length) report("out_length", len, w.length);
      if (data !== w.data) report("out_byte", data, w.data);
   endtask
endclass

module path_canonicalizer_tb;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [1:0] req_opcode = 2'd0;
   logic [7:0] req_path_byte = 8'd0;
   logic [7:0] req_read_index = 8'd0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [1:0] rsp_status;
   logic [7:0] rsp_out_length;
   logic [7:0] rsp_out_byte;

   path_scoreboard sb = new();

   // Number of request words accepted so far, and a flag that turns all idling
   // off for the final stretch of the run.
   int sent = 0;
   bit tail_quiet = 0;
   int cycle_count = 0;
   int stall_left = 0;

   path_canonicalizer u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_opcode     (req_opcode),
      .req_path_byte  (req_path_byte),
      .req_read_index (req_read_index),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_out_length (rsp_out_length),
      .rsp_out_byte   (rsp_out_byte)
   );

   always #5 clock = ~clock;

   // The result side stalls in random bursts. A recurring window is kept free of
   // stalls, and there are none at all near the end.
   always @(negedge clock) begin
      cycle_count++;
      if (tail_quiet || (cycle_count % 512) >= 448) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else if ($urandom_range(0, 5) == 0) begin
         rsp_stall <= 1'b1;
         stall_left = $urandom_range(0, 3);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // A result word is taken at the rising edge where valid is high and our stall is low.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0)
         sb.check_result(rsp_status, rsp_out_length, rsp_out_byte);
   end

   // Presents one request word from a falling edge on and holds it until the block
   // takes it. Now and then the sender first goes idle for a random burst;
   // every fourth block of 64 words goes without idling.
   task send_word(input opcode_type op, input logic [7:0] b, input logic [7:0] idx);
      int gap;
      begin
         @(negedge clock);
         if (!tail_quiet && (sent / 64) % 4 != 3 && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 4);
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         req_valid      <= 1'b1;
         req_opcode     <= op;
         req_path_byte  <= b;
         req_read_index <= idx;
         do @(posedge clock); while (req_stall !== 1'b0);
         sb.note_request(op, b, idx);
         sent++;
      end
   endtask

   // Unused fields of words sent by these helpers carry random values so that every bit moves.
   task send_text(input string s);
      int i;
      begin
         for (i = 0; i < s.len(); i++)
            send_word(OP_BYTE, s[i], 8'($urandom_range(0, 255)));
      end
   endtask

   task fill(input logic [7:0] c, input int n);
      repeat (n) send_word(OP_BYTE, c, 8'($urandom_range(0, 255)));
   endtask

   task close_path();
      send_word(OP_END, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
   endtask

   task read_at(input int idx);
      send_word(OP_READ, 8'($urandom_range(0, 255)), 8'(idx));
   endtask

   // Reads the whole canonical path plus the first position past its end.
   task read_all();
      int i;
      int n;
      begin
         n = sb.wpos;
         for (i = 0; i <= n && i < PATH_MAX; i++) read_at(i);
      end
   endtask

   // One random path: mostly well-formed components (names, dot, dot-dot, empty
   // ones from doubled slashes) with arbitrary name bytes, sprinkled with noise
   // words. About one path in 25 is made long, close to the size limit on input bytes.
   task random_path();
      int budget;
      int ncomp;
      int cnt;
      int j;
      int k;
      int n;
      logic [7:0] c;
      begin
         budget = ($urandom_range(0, 24) == 0) ? $urandom_range(230, 270) : 0;
         ncomp = (budget != 0) ? 400 : $urandom_range(0, 8);
         cnt = 0;
         if ($urandom_range(0, 3) != 0) begin
            send_word(OP_BYTE, CH_SLASH, 8'($urandom_range(0, 255)));
            cnt++;
         end
         for (j = 0; j < ncomp && (budget == 0 || cnt < budget); j++) begin
            if (j > 0) begin
               send_word(OP_BYTE, CH_SLASH, 8'($urandom_range(0, 255)));
               cnt++;
            end
            case ($urandom_range(0, 11))
               0: ;
               1: begin
                  send_text(".");
                  cnt += 1;
               end
               2: begin
                  send_text("..");
                  cnt += 2;
               end
               3: begin
                  send_text("...");
                  cnt += 3;
               end
               default: begin
                  n = $urandom_range(1, 5);
                  for (k = 0; k < n; k++) begin
                     c = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                     : 8'($urandom_range(97, 122));
                     if ($urandom_range(0, 9) == 0) c = CH_DOT;
                     send_word(OP_BYTE, c, 8'($urandom_range(0, 255)));
                     cnt++;
                  end
               end
            endcase
            // Noise words: reads of an open path answer zero, the spare opcode does nothing.
            if ($urandom_range(0, 29) == 0)
               send_word(opcode_type'($urandom_range(2, 3)), 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255)));
         end
         if ($urandom_range(0, 3) == 0)
            send_word(OP_BYTE, CH_SLASH, 8'($urandom_range(0, 255)));
         close_path();
         if ($urandom_range(0, 19) == 0) close_path();
         if ($urandom_range(0, 3) == 0) read_all();
         else begin
            repeat ($urandom_range(0, 3)) begin
               if ($urandom_range(0, 1) == 0) read_at($urandom_range(0, 255));
               else read_at((sb.wpos + 1 > 255) ? 255 : $urandom_range(0, sb.wpos + 1));
            end
         end
      end
   endtask

   initial begin
      int n;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // Directed part. A read straight after reset sees no path and answers zero;
      // an end with no bytes yields the root path alone.
      read_at(0);
      close_path();
      read_at(0);
      read_at(1);
      read_at(255);

      // Dot components vanish, dot-dot pops one name, doubled slashes collapse.
      send_text("/a/./b/../c//d/");
      close_path();
      read_all();

      // Dot-dot never climbs above the root.
      send_text("/../../x/..");
      close_path();
      read_all();

      // Three dots and names with dots in them are ordinary names; no leading slash.
      send_text(".../.a/a./...");
      // A zero byte is ignored, the spare opcode is inert, a read of an open path is zero.
      send_word(OP_BYTE, 8'h00, 8'hFF);
      send_word(OP_NONE, 8'hFF, 8'hFF);
      send_word(OP_READ, 8'hFF, 8'h00);
      send_word(OP_BYTE, 8'hFF, 8'h00);
      send_word(OP_BYTE, 8'h80, 8'h00);
      send_word(OP_BYTE, 8'h01, 8'h00);
      close_path();
      read_all();

      // Longest path that still fits: 254 name bytes give 255 output bytes.
      fill(8'h78, 254);
      close_path();
      read_at(254);
      read_at(255);

      // One more byte makes the output too long to report.
      fill(8'h78, 255);
      close_path();
      read_at(0);

      // The 256th byte of input is too many; later bytes are ignored until the end.
      fill(8'h79, 256);
      send_text("/z");
      close_path();
      read_at(1);

      // A 128th kept component overflows the component stack.
      repeat (127) send_text("a/");
      send_text("a");
      close_path();

      // A fresh path after a failed one works normally.
      send_text("b");
      close_path();
      read_all();

      // Random part; idling stops for the last couple of hundred words.
      while (sent < 2000) begin
         if (sent > 1800) tail_quiet = 1;
         random_path();
      end

      @(negedge clock);
      req_valid <= 1'b0;

      // Drain: wait for every outstanding result word, with a bound, then let the
      // two-stage pipeline settle so that any stray word would still be caught.
      for (n = 0; n < 2000 && sb.waiting.size() > 0; n++) @(posedge clock);
      repeat (8) @(posedge clock);
      if (sb.waiting.size() > 0) sb.report("missing result words", 0, sb.waiting.size());

      if (sb.errors == 0) begin
         $display("path_canonicalizer_tb: clean");
      end else begin
         $display("path_canonicalizer_tb: errors");
      end
      $finish;
   end

   // Watchdog: a correct run needs well under a tenth of this time.
   initial begin
      #10000000;
      $display("path_canonicalizer_tb: errors");
      $finish;
   end

endmodule
